// ===== hdl/salc_pkg.sv =====
// Shared types, constants and helpers for the set-associative LRU cache model.
// No dependencies; every other file of the block but salc_ram imports this package.
`default_nettype none

package salc_pkg;

	// Geometry
	localparam int SET_BITS_MAX = 6;
	localparam int WAYS_MAX     = 8;
	localparam int SETS         = 1 << SET_BITS_MAX;
	localparam int SET_IDX_W    = SET_BITS_MAX;
	localparam int WAY_IDX_W    = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
	localparam int WAY_CNT_W    = $clog2(WAYS_MAX + 1);
	localparam int SB_W         = $clog2(SET_BITS_MAX + 1);

	// Field widths
	localparam int ADDR_W      = 64;
	localparam int TAG_W       = 62;
	localparam int STAMP_W     = 32;
	localparam int CNT_W       = 32;
	localparam int WAY_OUT_W   = 3;
	localparam int BLOCK_W     = 6;
	localparam int SHIFT_W     = 7;
	localparam int BLOCK_MAX   = 32;

	localparam logic [CNT_W-1:0] SAT_VAL = 32'hFFFF_FFFF;

	// Configuration port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WAYS       = 2'd2;

	localparam logic [2:0] SET_BITS_RST   = 3'd1;
	localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
	localparam logic [3:0] WAYS_RST       = 4'd1;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	// One cache line and one set row as held in memory
	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	typedef line_t [WAYS_MAX-1:0] row_t;

	// Clamped configuration in use
	typedef struct packed {
		logic [SB_W-1:0]      set_bits;
		logic [BLOCK_W-1:0]   block_bits;
		logic [WAY_CNT_W-1:0] ways;
	} cfg_t;

	// Lookup decision for one access
	typedef struct packed {
		logic                 hit;
		logic [WAY_IDX_W-1:0] way;
		logic                 victim_valid;
	} pick_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == SAT_VAL) ? SAT_VAL : v + 1'b1;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/salc_ifs.sv =====
// Valid/ready channel interfaces: address request in, access result out.
// Depends on salc_pkg.
`default_nettype none

interface salc_req_if;
	import salc_pkg::*;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output address, input ready);
	modport sink   (input valid, input address, output ready);
endinterface

interface salc_res_if;
	import salc_pkg::*;
	logic                 valid;
	logic                 ready;
	outcome_t             outcome;
	logic [WAY_OUT_W-1:0] way_used;
	logic [CNT_W-1:0]     hits_total;
	logic [CNT_W-1:0]     misses_total;
	logic [CNT_W-1:0]     evictions_total;

	modport source (output valid, output outcome, output way_used, output hits_total,
		output misses_total, output evictions_total, input ready);
	modport sink   (input valid, input outcome, input way_used, input hits_total,
		input misses_total, input evictions_total, output ready);
endinterface

`default_nettype wire

// ===== hdl/set_assoc_lru_cache_model_top.sv =====
// Top level of the set-associative LRU cache model: request/result channels,
// configuration port, set memory and access control. Depends on salc_pkg,
// salc_ifs, salc_ram, salc_cfg and salc_pick.
//
// Each address word passes through the idle and lookup states: on accept the set
// row (all ways with valid, tag and stamp) is read from the set memory into its
// registered read port, and in the lookup state the ways are compared, the hit or
// LRU victim is chosen, the row is written back and the result word is loaded
// into the output register. A new address is taken only after the last one is
// committed; a result not yet taken downstream holds the block in the lookup
// state. Reset clears one valid flop per set row, so there is no memory clearing
// pass and the block is ready as soon as reset is released. Configuration values
// outside their range are clamped.
`default_nettype none

module set_assoc_lru_cache_model_top (
	input  logic                        clk,
	input  logic                        arst_n,
	salc_req_if.sink                    req,
	salc_res_if.source                  res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [salc_pkg::APB_AW-1:0] paddr,
	input  logic [salc_pkg::APB_DW-1:0] pwdata,
	output logic [salc_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import salc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LOOK = 2'b10
	} state_t;

	state_t                state_q;
	cfg_t                  cfg;
	pick_t                 pick;

	logic                  accept;
	logic                  commit;
	logic [ADDR_W-1:0]     addr_shifted;
	logic [ADDR_W-1:0]     tag_shifted;
	logic [SHIFT_W-1:0]    tag_shift;
	logic [SET_IDX_W-1:0]  set_mask;
	logic [SET_IDX_W-1:0]  set_idx;
	logic [TAG_W-1:0]      tag;

	logic [SET_IDX_W-1:0]  set_s1;
	logic [TAG_W-1:0]      tag_s1;
	logic                  rowv_s1;

	logic [SETS-1:0]       row_valid_q;
	row_t                  ram_rdata;
	row_t                  row_rd;
	row_t                  row_wr;

	logic [STAMP_W-1:0]    stamp_q;
	logic [STAMP_W-1:0]    stamp_next;
	logic [CNT_W-1:0]      hit_q;
	logic [CNT_W-1:0]      miss_q;
	logic [CNT_W-1:0]      evict_q;

	logic                  res_valid_q;
	outcome_t              res_outcome_q;
	logic [WAY_OUT_W-1:0]  res_way_q;

	salc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Split the address into set index and tag
	always_comb begin
		addr_shifted = req.address >> cfg.block_bits;
		tag_shift    = SHIFT_W'(cfg.set_bits) + SHIFT_W'(cfg.block_bits);
		tag_shifted  = req.address >> tag_shift;
		tag          = tag_shifted[TAG_W-1:0];
		for (int i = 0; i < SET_IDX_W; i++) begin
			set_mask[i] = (i < int'(cfg.set_bits));
		end
		set_idx = addr_shifted[SET_IDX_W-1:0] & set_mask;
	end

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign commit    = (state_q == ST_LOOK) && (!res_valid_q || res.ready);

	salc_ram #(
		.DEPTH (SETS),
		.WIDTH ($bits(row_t))
	) u_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (set_s1),
		.wdata (row_wr),
		.re    (accept),
		.raddr (set_idx),
		.rdata (ram_rdata)
	);

	// A row never written since reset reads as all zero
	assign row_rd = rowv_s1 ? ram_rdata : '0;

	salc_pick u_pick (
		.row  (row_rd),
		.tag  (tag_s1),
		.ways (cfg.ways),
		.pick (pick)
	);

	// Refresh the hit line, or refill the victim
	assign stamp_next = sat_inc(stamp_q);
	always_comb begin
		row_wr = row_rd;
		row_wr[pick.way].stamp = stamp_next;
		if (!pick.hit) begin
			row_wr[pick.way].valid = 1'b1;
			row_wr[pick.way].tag   = tag_s1;
		end
	end

	// Capture the lookup key at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1  <= set_idx;
			tag_s1  <= tag;
			rowv_s1 <= row_valid_q[set_idx];
		end
	end

	// Sequencer, row valid flags, stamp and tallies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_valid_q <= '0;
			stamp_q     <= '0;
			hit_q       <= '0;
			miss_q      <= '0;
			evict_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (commit) begin
				row_valid_q[set_s1] <= 1'b1;
				stamp_q             <= stamp_next;
				if (pick.hit) begin
					hit_q <= sat_inc(hit_q);
				end else begin
					miss_q <= sat_inc(miss_q);
					if (pick.victim_valid) begin
						evict_q <= sat_inc(evict_q);
					end
				end
			end
		end
	end

	// Result register: advance on commit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_way_q <= WAY_OUT_W'(pick.way);
			if (pick.hit) begin
				res_outcome_q <= OUT_HIT;
			end else if (pick.victim_valid) begin
				res_outcome_q <= OUT_EVICT;
			end else begin
				res_outcome_q <= OUT_FILL;
			end
		end
	end

	assign res.valid           = res_valid_q;
	assign res.outcome         = res_outcome_q;
	assign res.way_used        = res_way_q;
	assign res.hits_total      = hit_q;
	assign res.misses_total    = miss_q;
	assign res.evictions_total = evict_q;

	// Checks
	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_LOOK)
		else $error("lookup cycle did not follow an accepted address");

	a_evict_le_miss: assert property (@(posedge clk) disable iff (!arst_n)
		evict_q <= miss_q)
		else $error("eviction tally exceeds miss tally");

	a_tally_le_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q <= stamp_q && miss_q <= stamp_q)
		else $error("hit or miss tally exceeds access stamp");

	a_row_marked: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> row_valid_q[$past(set_s1)])
		else $error("written set row not marked valid");

endmodule

`default_nettype wire

// ===== hdl/salc_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module salc_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/salc_cfg.sv =====
// APB-style configuration registers and clamping of the values in use.
// Depends on salc_pkg.
`default_nettype none

module salc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [salc_pkg::APB_AW-1:0] paddr,
	input  logic [salc_pkg::APB_DW-1:0] pwdata,
	output logic [salc_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output salc_pkg::cfg_t              cfg
);
	import salc_pkg::*;

	logic [2:0]           set_bits_q;
	logic [BLOCK_W-1:0]   block_bits_q;
	logic [3:0]           ways_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= SET_BITS_RST;
			block_bits_q <= BLOCK_BITS_RST;
			ways_q       <= WAYS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SET_BITS:   set_bits_q   <= pwdata[2:0];
				REG_BLOCK_BITS: block_bits_q <= pwdata[BLOCK_W-1:0];
				REG_WAYS:       ways_q       <= pwdata[3:0];
				default:        ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_SET_BITS:   prdata = APB_DW'(set_bits_q);
			REG_BLOCK_BITS: prdata = APB_DW'(block_bits_q);
			REG_WAYS:       prdata = APB_DW'(ways_q);
			default:        prdata = '0;
		endcase
	end

	// Clamp each value into its working range
	always_comb begin
		if (set_bits_q == 3'd0) begin
			cfg.set_bits = SB_W'(1);
		end else if (int'(set_bits_q) > SET_BITS_MAX) begin
			cfg.set_bits = SB_W'(SET_BITS_MAX);
		end else begin
			cfg.set_bits = SB_W'(set_bits_q);
		end

		if (block_bits_q == '0) begin
			cfg.block_bits = BLOCK_W'(1);
		end else if (int'(block_bits_q) > BLOCK_MAX) begin
			cfg.block_bits = BLOCK_W'(BLOCK_MAX);
		end else begin
			cfg.block_bits = block_bits_q;
		end

		if (ways_q == 4'd0) begin
			cfg.ways = WAY_CNT_W'(1);
		end else if (int'(ways_q) > WAYS_MAX) begin
			cfg.ways = WAY_CNT_W'(WAYS_MAX);
		end else begin
			cfg.ways = WAY_CNT_W'(ways_q);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/salc_pick.sv =====
// Way selection for one set row: tag match across the ways and LRU victim
// search through a small comparison tree. Depends on salc_pkg.
`default_nettype none

module salc_pick (
	input  salc_pkg::row_t                  row,
	input  logic [salc_pkg::TAG_W-1:0]      tag,
	input  logic [salc_pkg::WAY_CNT_W-1:0]  ways,
	output salc_pkg::pick_t                 pick
);
	import salc_pkg::*;

	localparam int LEAVES = 1 << WAY_IDX_W;

	logic                 hit;
	logic [WAY_IDX_W-1:0] hit_way;
	logic [STAMP_W:0]     node_key [1:2*LEAVES-1];
	logic [WAY_IDX_W-1:0] node_way [1:2*LEAVES-1];
	logic [WAY_IDX_W-1:0] victim;

	// Tag match, lowest matching way wins
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = WAYS_MAX - 1; w >= 0; w--) begin
			if (w < int'(ways) && row[w].valid && row[w].tag == tag) begin
				hit     = 1'b1;
				hit_way = WAY_IDX_W'(w);
			end
		end
	end

	// Minimum stamp; ways not in use rank last, left side wins a tie
	always_comb begin
		for (int i = 0; i < LEAVES; i++) begin
			node_way[LEAVES + i] = WAY_IDX_W'(i);
			if (i < WAYS_MAX && i < int'(ways)) begin
				node_key[LEAVES + i] = {1'b0, row[i].stamp};
			end else begin
				node_key[LEAVES + i] = '1;
			end
		end
		for (int n = LEAVES - 1; n >= 1; n--) begin
			if (node_key[2*n+1] < node_key[2*n]) begin
				node_key[n] = node_key[2*n+1];
				node_way[n] = node_way[2*n+1];
			end else begin
				node_key[n] = node_key[2*n];
				node_way[n] = node_way[2*n];
			end
		end
		victim = node_way[1];
	end

	assign pick.hit          = hit;
	assign pick.way          = hit ? hit_way : victim;
	assign pick.victim_valid = row[victim].valid;

endmodule

`default_nettype wire
